// ===== hdl/alpha_blend_over_pixel_macros.svh =====
// ----------------------------------------------------------------------------
// alpha_blend_over_pixel_macros
// Assertion macros for the alpha blend over pixel block.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_OVER_PIXEL_MACROS_SVH
`define ALPHA_BLEND_OVER_PIXEL_MACROS_SVH
`ifndef NO_ASSERTIONS
// The condition holds at every clock edge out of reset.
`define ABOP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");
// When the trigger holds, the consequence holds at the next edge.
`define ABOP_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed: next-cycle property");
`else
`define ABOP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ABOP_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif
`endif

// ===== hdl/abop_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abop_pkg
// Shared types and constants of the alpha blend over pixel block.
// ----------------------------------------------------------------------------
package abop_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int NUM_W      = 24;
    localparam int Q_W        = 8;
    localparam int AL_W       = 16;

    localparam logic [7:0] FULL_ALPHA = 8'hFF;

    // Reciprocal of 255 scaled by 2**23; exact for every alpha sum up to 255*255.
    localparam logic [AL_W-1:0] INV_255   = 16'h8081;
    localparam int              INV_SHIFT = 23;

    // Lane order of every pixel vector.
    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;
    localparam int LANE_ALPHA = 3;

    typedef logic [3:0][7:0] t_pixel;

    typedef struct packed {
        logic [2:0][7:0] s;
        logic [2:0][7:0] d;
        logic [AL_W-1:0] u;
        logic [AL_W-1:0] v;
        logic            bypass;
        t_pixel          pix;
        logic            wr;
    } t_front;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [AL_W-1:0]       al;
        logic [3:0][Q_W-1:0]   q;
        logic                  bypass;
        t_pixel                pix;
        logic                  wr;
    } t_div;

    typedef struct packed {
        logic [FIFO_AW:0] count;
        logic             full;
    } t_fifo_status;

endpackage
`default_nettype wire

// ===== hdl/alpha_blend_over_pixel.sv =====
`default_nettype none
`include "alpha_blend_over_pixel_macros.svh"
// ----------------------------------------------------------------------------
// alpha_blend_over_pixel
// Blend-over of a non-premultiplied BGRA source pixel onto a canvas pixel.
//
//   channel   handshake           payload
//   input     push / full         i_src_*, i_dst_* (8 bits each)
//   result    empty / pop         o_out_*, o_write_pixel
//
// One item per cycle is sustained while results are popped. A result passes
// through one front register, one queue slot, one multiply stage and eight
// divider stages of one quotient bit each before it can be popped. Reset is
// synchronous and empties every stage and the queue. A stalled result holds
// the divider pipeline; the queue then fills and full rises.
// ----------------------------------------------------------------------------
module alpha_blend_over_pixel (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_src_blue,
    input  wire logic [7:0] i_src_green,
    input  wire logic [7:0] i_src_red,
    input  wire logic [7:0] i_src_alpha,
    input  wire logic [7:0] i_dst_blue,
    input  wire logic [7:0] i_dst_green,
    input  wire logic [7:0] i_dst_red,
    input  wire logic [7:0] i_dst_alpha,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_blue,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_red,
    output logic [7:0]      o_out_alpha,
    output logic            o_write_pixel
);
    import abop_pkg::*;

    t_pixel       src;
    t_pixel       dst;
    t_pixel       res;
    logic         f_valid;
    t_front       f_data;
    logic         q_ready;
    logic         q_valid;
    t_front       q_data;
    logic         q_take;
    t_fifo_status q_status;

    assign src = {i_src_alpha, i_src_red, i_src_green, i_src_blue};
    assign dst = {i_dst_alpha, i_dst_red, i_dst_green, i_dst_blue};

    abop_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_src   (src),
        .i_dst   (dst),
        .o_valid (f_valid),
        .o_data  (f_data),
        .i_ready (q_ready)
    );

    abop_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid),
        .i_data   (f_data),
        .o_ready  (q_ready),
        .o_valid  (q_valid),
        .o_data   (q_data),
        .i_pop    (q_take),
        .o_status (q_status)
    );

    abop_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_take  (q_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_pix   (res),
        .o_wr    (o_write_pixel)
    );

    assign o_out_blue  = res[LANE_BLUE];
    assign o_out_green = res[LANE_GREEN];
    assign o_out_red   = res[LANE_RED];
    assign o_out_alpha = res[LANE_ALPHA];

    `ABOP_ASSERT_ALWAYS(a_fifo_bound, i_clk, i_rst_n, q_status.count <= (FIFO_AW+1)'(FIFO_DEPTH))
    `ABOP_ASSERT_ALWAYS(a_full_only_when_queue_full, i_clk, i_rst_n, !full || q_status.full)
    `ABOP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty && $stable(res) && $stable(o_write_pixel))

endmodule
`default_nettype wire

// ===== hdl/abop_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abop_front
// Accepts pixel items, sorts out the trivial cases and forms the weights.
// ----------------------------------------------------------------------------
module abop_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire abop_pkg::t_pixel i_src,
    input  wire abop_pkg::t_pixel i_dst,
    output logic                 o_valid,
    output abop_pkg::t_front     o_data,
    input  wire logic            i_ready
);
    import abop_pkg::*;

    logic   r_valid;
    t_front r_data;
    t_front n_data;
    logic   accept;

    assign o_full  = r_valid && !i_ready;
    assign accept  = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_data.s[c] = i_src[c];
            n_data.d[c] = i_dst[c];
        end
        n_data.u = AL_W'(i_src[LANE_ALPHA]) * AL_W'(FULL_ALPHA);
        n_data.v = AL_W'(FULL_ALPHA - i_src[LANE_ALPHA]) * AL_W'(i_dst[LANE_ALPHA]);
        if (i_src[LANE_ALPHA] == 8'd0) begin
            // Transparent source: the canvas keeps its pixel.
            n_data.bypass = 1'b1;
            n_data.pix    = i_dst;
            n_data.wr     = 1'b0;
        end else if (i_src[LANE_ALPHA] == FULL_ALPHA || i_dst[LANE_ALPHA] == 8'd0) begin
            n_data.bypass = 1'b1;
            n_data.pix    = i_src;
            n_data.wr     = 1'b1;
        end else begin
            n_data.bypass = 1'b0;
            n_data.pix    = i_src;
            n_data.wr     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/abop_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abop_fifo
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module abop_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire abop_pkg::t_front  i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output abop_pkg::t_front       o_data,
    input  wire logic              i_pop,
    output abop_pkg::t_fifo_status o_status
);
    import abop_pkg::*;

    t_front             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               full;
    logic               wr_en;
    logic               rd_en;

    assign full            = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_ready         = !full;
    assign o_valid         = (r_count != '0);
    assign o_data          = mem[r_rd_ptr];
    assign wr_en           = i_push && !full;
    assign rd_en           = i_pop && o_valid;
    assign o_status.count  = r_count;
    assign o_status.full   = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/abop_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abop_back
// Forms the weighted sums and divides the colour sums, one quotient bit per stage.
// ----------------------------------------------------------------------------
module abop_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire abop_pkg::t_front i_data,
    output logic                  o_take,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output abop_pkg::t_pixel      o_pix,
    output logic                  o_wr
);
    import abop_pkg::*;

    logic [Q_W:0] r_v;
    t_div         r_st [Q_W+1];
    t_div         n_st [Q_W+1];
    logic [Q_W:0] go;
    logic [NUM_W-1:0] dsh;
    logic [2*AL_W-1:0] al_scaled;

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        go[Q_W] = !r_v[Q_W] || i_pop;
        for (int k = Q_W - 1; k >= 0; k--) begin
            go[k] = !r_v[k] || go[k+1];
        end
    end

    assign o_take = i_valid && go[0];

    always_comb begin
        dsh = '0;
        n_st[0].al     = i_data.u + i_data.v;
        n_st[0].q      = '0;
        n_st[0].bypass = i_data.bypass;
        n_st[0].pix    = i_data.pix;
        n_st[0].wr     = i_data.wr;
        for (int c = 0; c < 3; c++) begin
            n_st[0].rem[c] = NUM_W'(NUM_W'(i_data.s[c]) * NUM_W'(i_data.u))
                           + NUM_W'(NUM_W'(i_data.d[c]) * NUM_W'(i_data.v));
        end
        // The alpha is divided by 255 at once through a reciprocal multiply.
        al_scaled = (2*AL_W)'(n_st[0].al) * (2*AL_W)'(INV_255);
        n_st[0].q[LANE_ALPHA] = al_scaled[INV_SHIFT +: Q_W];
        // Stage k decides quotient bit Q_W-k; every quotient stays below 256.
        for (int k = 1; k <= Q_W; k++) begin
            n_st[k] = r_st[k-1];
            dsh = NUM_W'(r_st[k-1].al) << (Q_W - k);
            for (int c = 0; c < 3; c++) begin
                if (r_st[k-1].rem[c] >= dsh) begin
                    n_st[k].rem[c]         = r_st[k-1].rem[c] - dsh;
                    n_st[k].q[c][Q_W - k]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (go[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= Q_W; k++) begin
                if (go[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= Q_W; k++) begin
            if (go[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_empty = !r_v[Q_W];
    assign o_pix   = r_st[Q_W].bypass ? r_st[Q_W].pix : t_pixel'(r_st[Q_W].q);
    assign o_wr    = r_st[Q_W].wr;

endmodule
`default_nettype wire
